FILE: rtl/core/frd_pkg.sv
package frd_pkg;

  // field width of numerator, denominator and results
  localparam int DATA_WIDTH = 32;
  localparam int CNT_WIDTH  = $clog2(DATA_WIDTH + 1);

  // stream widths, whole bytes
  localparam int IN_BITS   = 2 * DATA_WIDTH;
  localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 2 * DATA_WIDTH;
  localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

  // microcode step addresses
  localparam int STEP_WIDTH = 4;
  localparam logic [STEP_WIDTH-1:0] ST_IDLE     = 4'd0;
  localparam logic [STEP_WIDTH-1:0] ST_CHECK    = 4'd1;
  localparam logic [STEP_WIDTH-1:0] ST_EUC_DIV  = 4'd2;
  localparam logic [STEP_WIDTH-1:0] ST_EUC_WAIT = 4'd3;
  localparam logic [STEP_WIDTH-1:0] ST_EUC_SWAP = 4'd4;
  localparam logic [STEP_WIDTH-1:0] ST_NUM_DIV  = 4'd5;
  localparam logic [STEP_WIDTH-1:0] ST_NUM_WAIT = 4'd6;
  localparam logic [STEP_WIDTH-1:0] ST_DEN_DIV  = 4'd7;
  localparam logic [STEP_WIDTH-1:0] ST_DEN_WAIT = 4'd8;
  localparam logic [STEP_WIDTH-1:0] ST_SAVE_DEN = 4'd9;
  localparam logic [STEP_WIDTH-1:0] ST_EMIT     = 4'd10;
  localparam logic [STEP_WIDTH-1:0] ST_EMIT_ERR = 4'd11;

  // datapath operations
  localparam logic [3:0] OP_NOP        = 4'd0;
  localparam logic [3:0] OP_LOAD       = 4'd1;
  localparam logic [3:0] OP_DIV_XY     = 4'd2;
  localparam logic [3:0] OP_SWAP       = 4'd3;
  localparam logic [3:0] OP_DIV_NG     = 4'd4;
  localparam logic [3:0] OP_SAVE_N_DIV = 4'd5;
  localparam logic [3:0] OP_SAVE_D     = 4'd6;
  localparam logic [3:0] OP_EMIT       = 4'd7;
  localparam logic [3:0] OP_EMIT_ERR   = 4'd8;

  // branch conditions
  localparam logic [2:0] CD_ALWAYS   = 3'd0;
  localparam logic [2:0] CD_IN_VALID = 3'd1;
  localparam logic [2:0] CD_D_ZERO   = 3'd2;
  localparam logic [2:0] CD_DIV_DONE = 3'd3;
  localparam logic [2:0] CD_REM_ZERO = 3'd4;
  localparam logic [2:0] CD_OUT_FREE = 3'd5;

  typedef struct packed {
    logic [3:0]            op;
    logic [2:0]            cond;
    logic [STEP_WIDTH-1:0] t_true;
    logic [STEP_WIDTH-1:0] t_false;
  } ctrl_t;

  function automatic ctrl_t mk(input logic [3:0] op, input logic [2:0] cond,
                               input logic [STEP_WIDTH-1:0] t_true,
                               input logic [STEP_WIDTH-1:0] t_false);
    ctrl_t c;
    c.op      = op;
    c.cond    = cond;
    c.t_true  = t_true;
    c.t_false = t_false;
    return c;
  endfunction

  // control store: one word per step
  function automatic ctrl_t ucode(input logic [STEP_WIDTH-1:0] step);
    ctrl_t c;
    unique case (step)
      ST_IDLE:     c = mk(OP_LOAD,       CD_IN_VALID, ST_CHECK,    ST_IDLE);
      ST_CHECK:    c = mk(OP_NOP,        CD_D_ZERO,   ST_EMIT_ERR, ST_EUC_DIV);
      ST_EUC_DIV:  c = mk(OP_DIV_XY,     CD_ALWAYS,   ST_EUC_WAIT, ST_EUC_WAIT);
      ST_EUC_WAIT: c = mk(OP_NOP,        CD_DIV_DONE, ST_EUC_SWAP, ST_EUC_WAIT);
      ST_EUC_SWAP: c = mk(OP_SWAP,       CD_REM_ZERO, ST_NUM_DIV,  ST_EUC_DIV);
      ST_NUM_DIV:  c = mk(OP_DIV_NG,     CD_ALWAYS,   ST_NUM_WAIT, ST_NUM_WAIT);
      ST_NUM_WAIT: c = mk(OP_NOP,        CD_DIV_DONE, ST_DEN_DIV,  ST_NUM_WAIT);
      ST_DEN_DIV:  c = mk(OP_SAVE_N_DIV, CD_ALWAYS,   ST_DEN_WAIT, ST_DEN_WAIT);
      ST_DEN_WAIT: c = mk(OP_NOP,        CD_DIV_DONE, ST_SAVE_DEN, ST_DEN_WAIT);
      ST_SAVE_DEN: c = mk(OP_SAVE_D,     CD_ALWAYS,   ST_EMIT,     ST_EMIT);
      ST_EMIT:     c = mk(OP_EMIT,       CD_OUT_FREE, ST_IDLE,     ST_EMIT);
      ST_EMIT_ERR: c = mk(OP_EMIT_ERR,   CD_OUT_FREE, ST_IDLE,     ST_EMIT_ERR);
      default:     c = mk(OP_NOP,        CD_ALWAYS,   ST_IDLE,     ST_IDLE);
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/fraction_reducer_core.sv
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata: numerator, denominator
// m_        out  m_tvalid/m_tready  m_tdata: reduced_numerator, reduced_denominator;
//                                   m_tuser: zero_denominator
//
// one request at a time through a microcoded sequencer and one shared
// restoring divider that resolves one quotient bit per cycle. a request
// runs euclid remainder steps, then the two final divisions and emit;
// a zero denominator goes from the check straight to an error result.
// rst is synchronous and returns the step counter to idle, output empty.
// the output register holds a result until taken; a new request is taken
// while the previous result still waits on m_tready.
module fraction_reducer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // numerator [31:0], denominator [63:32]
  input  logic [frd_pkg::IN_TDATA-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // reduced_numerator [31:0], reduced_denominator [63:32]
  output logic [frd_pkg::OUT_TDATA-1:0] m_tdata,
  // zero_denominator [0]
  output logic                          m_tuser
);

  localparam int W = frd_pkg::DATA_WIDTH;

  logic [frd_pkg::STEP_WIDTH-1:0] step;
  logic [frd_pkg::STEP_WIDTH-1:0] step_next;
  frd_pkg::ctrl_t                 ctrl;
  logic                           cond_ok;

  // euclid and result registers
  logic [W-1:0] x_reg;
  logic [W-1:0] y_reg;
  logic [W-1:0] num_mag;
  logic [W-1:0] den_mag;
  logic [W-1:0] res_n;
  logic [W-1:0] res_d;
  logic         sign_n;
  logic         sign_d;

  // shared divider
  logic [W-1:0]                    div_quo;
  logic [W-1:0]                    div_rem;
  logic [W-1:0]                    div_dvs;
  logic [frd_pkg::CNT_WIDTH-1:0]   div_cnt;
  logic [W:0]                      div_shift;
  logic [W:0]                      div_diff;
  logic                            div_start;
  logic [W-1:0]                    div_a;
  logic [W-1:0]                    div_b;

  logic [W-1:0] in_n;
  logic [W-1:0] in_d;
  logic         out_free;

  assign in_n     = s_tdata[W-1:0];
  assign in_d     = s_tdata[2*W-1:W];
  assign out_free = !m_tvalid || m_tready;

  // control word fetch and branch
  assign ctrl     = frd_pkg::ucode(step);
  assign s_tready = (ctrl.op == frd_pkg::OP_LOAD);

  always_comb begin
    case (ctrl.cond)
      frd_pkg::CD_ALWAYS:   cond_ok = 1'b1;
      frd_pkg::CD_IN_VALID: cond_ok = s_tvalid;
      frd_pkg::CD_D_ZERO:   cond_ok = (y_reg == '0);
      frd_pkg::CD_DIV_DONE: cond_ok = (div_cnt == '0);
      frd_pkg::CD_REM_ZERO: cond_ok = (div_rem == '0);
      frd_pkg::CD_OUT_FREE: cond_ok = out_free;
      default:              cond_ok = 1'b1;
    endcase
    step_next = cond_ok ? ctrl.t_true : ctrl.t_false;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= frd_pkg::ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_a     = x_reg;
    div_b     = y_reg;
    unique case (ctrl.op)
      frd_pkg::OP_DIV_XY: begin
        div_start = 1'b1;
      end
      frd_pkg::OP_DIV_NG: begin
        div_start = 1'b1;
        div_a     = num_mag;
        div_b     = x_reg;
      end
      frd_pkg::OP_SAVE_N_DIV: begin
        div_start = 1'b1;
        div_a     = den_mag;
        div_b     = x_reg;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // one restoring step per cycle
  assign div_shift = {div_rem, div_quo[W-1]};
  assign div_diff  = div_shift - {1'b0, div_dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_start) begin
      div_cnt <= frd_pkg::CNT_WIDTH'(W);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_quo <= div_a;
      div_rem <= '0;
      div_dvs <= div_b;
    end else if (div_cnt != '0) begin
      if (!div_diff[W]) begin
        div_rem <= div_diff[W-1:0];
        div_quo <= {div_quo[W-2:0], 1'b1};
      end else begin
        div_rem <= div_shift[W-1:0];
        div_quo <= {div_quo[W-2:0], 1'b0};
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      frd_pkg::OP_LOAD: begin
        if (s_tvalid) begin
          sign_n  <= in_n[W-1];
          sign_d  <= in_d[W-1];
          x_reg   <= in_n[W-1] ? (W'(0) - in_n) : in_n;
          y_reg   <= in_d[W-1] ? (W'(0) - in_d) : in_d;
          num_mag <= in_n[W-1] ? (W'(0) - in_n) : in_n;
          den_mag <= in_d[W-1] ? (W'(0) - in_d) : in_d;
        end
      end
      frd_pkg::OP_SWAP: begin
        x_reg <= y_reg;
        y_reg <= div_rem;
      end
      frd_pkg::OP_SAVE_N_DIV: begin
        res_n <= div_quo;
      end
      frd_pkg::OP_SAVE_D: begin
        res_d <= div_quo;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((ctrl.op == frd_pkg::OP_EMIT || ctrl.op == frd_pkg::OP_EMIT_ERR)
                 && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (ctrl.op == frd_pkg::OP_EMIT) begin
        m_tdata <= frd_pkg::OUT_TDATA'({sign_d ? (W'(0) - res_d) : res_d,
                                        sign_n ? (W'(0) - res_n) : res_n});
        m_tuser <= 1'b0;
      end else if (ctrl.op == frd_pkg::OP_EMIT_ERR) begin
        m_tdata <= '0;
        m_tuser <= 1'b1;
      end
    end
  end

endmodule
